@@ hdl/tnrx_pkg.sv @@
// tnrx_pkg: telnet command codes and parser state type for the receive stripper
// no dependencies

package tnrx_pkg;

  // telnet command bytes
  localparam logic [7:0] CodeSe   = 8'd240;
  localparam logic [7:0] CodeGa   = 8'd249;
  localparam logic [7:0] CodeSb   = 8'd250;
  localparam logic [7:0] CodeWill = 8'd251;
  localparam logic [7:0] CodeWont = 8'd252;
  localparam logic [7:0] CodeDo   = 8'd253;
  localparam logic [7:0] CodeDont = 8'd254;
  localparam logic [7:0] CodeIac  = 8'd255;

  // reply beat positions
  localparam logic [1:0] BeatFirst = 2'd0;
  localparam logic [1:0] BeatCmd   = 2'd1;
  localparam logic [1:0] BeatLast  = 2'd2;

  // parser state, one-hot
  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StIac    = 5'b00010,
    StOpt    = 5'b00100,
    StSub    = 5'b01000,
    StSubIac = 5'b10000
  } parse_state_e;

endpackage

@@ hdl/telnet_rx_command_stripper_unit.sv @@
// telnet_rx_command_stripper_unit: strips telnet command sequences from a received byte
// stream and emits refusal replies; depends on tnrx_pkg
//
// Received bytes enter on the slave stream one per transfer. Plain data (and IAC IAC as
// one 255 byte) leaves on the master stream with tuser = 0. Two-byte commands, WONT/DONT
// with option, and subnegotiations up to IAC SE are dropped. DO opt is answered with the
// three-beat reply IAC WONT opt, and WILL opt with IAC DONT opt, all with tuser = 1; tlast
// marks the final beat caused by one input byte. The parser state updates in the cycle a
// byte is taken and the result sits in a one-entry output register, so one byte is taken
// per cycle as long as the output side keeps up; a reply holds the input while its further
// beats occupy that register.

module telnet_rx_command_stripper_unit
  import tnrx_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] rx_byte
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tuser_o,   // [0] to_peer
  output logic       m_axis_tlast_o    // last
);

  parse_state_e state_q, state_d;
  logic [7:0]   held_q, held_d;

  logic       out_vld_q, out_vld_d;
  logic       out_peer_q, out_peer_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic [7:0] reply_cmd_q, reply_cmd_d;
  logic [1:0] beat_q, beat_d;

  logic in_xfer, out_xfer, out_done;
  logic emit_data, emit_reply;
  logic [7:0] b;

  assign b = s_axis_tdata_i;

  // output side: a beat is final for data, or at the last reply position
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = out_peer_q;
  assign m_axis_tlast_o  = !out_peer_q || (beat_q == BeatLast);
  assign out_xfer        = out_vld_q && m_axis_tready_i;
  assign out_done        = out_xfer && m_axis_tlast_o;

  always_comb begin
    case (beat_q)
      BeatFirst: m_axis_tdata_o = out_peer_q ? CodeIac : out_byte_q;
      BeatCmd:   m_axis_tdata_o = reply_cmd_q;
      default:   m_axis_tdata_o = out_byte_q;
    endcase
  end

  // input is taken when the output register is free or empties now
  assign s_axis_tready_o = !out_vld_q || out_done;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  // parser next state and result decision
  always_comb begin
    state_d    = state_q;
    held_d     = held_q;
    emit_data  = 1'b0;
    emit_reply = 1'b0;
    case (state_q)
      StIac: begin
        if (b == CodeIac) begin
          state_d   = StIdle;
          emit_data = 1'b1;
        end else if (b inside {[CodeWill:CodeDont]}) begin
          held_d  = b;
          state_d = StOpt;
        end else if (b == CodeSb) begin
          state_d = StSub;
        end else begin
          // two-byte command or unknown byte below SE
          state_d = StIdle;
        end
      end
      StOpt: begin
        state_d    = StIdle;
        emit_reply = (held_q == CodeDo) || (held_q == CodeWill);
      end
      StSub: begin
        if (b == CodeIac) state_d = StSubIac;
      end
      StSubIac: begin
        // SE closes, escaped IAC or stray byte goes back to the body
        state_d = (b == CodeSe) ? StIdle : StSub;
      end
      default: begin
        if (b == CodeIac) begin
          state_d = StIac;
        end else begin
          state_d   = StIdle;
          emit_data = 1'b1;
        end
      end
    endcase
  end

  // output register load and beat stepping
  always_comb begin
    out_vld_d   = out_vld_q;
    out_peer_d  = out_peer_q;
    out_byte_d  = out_byte_q;
    reply_cmd_d = reply_cmd_q;
    beat_d      = beat_q;
    if (out_done) begin
      out_vld_d = 1'b0;
    end else if (out_xfer) begin
      beat_d = beat_q + 2'd1;
    end
    if (in_xfer && (emit_data || emit_reply)) begin
      out_vld_d   = 1'b1;
      out_peer_d  = emit_reply;
      out_byte_d  = b;
      reply_cmd_d = (held_q == CodeDo) ? CodeWont : CodeDont;
      beat_d      = BeatFirst;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      held_q    <= 8'd0;
      out_vld_q <= 1'b0;
      beat_q    <= BeatFirst;
    end else begin
      if (in_xfer) begin
        state_q <= state_d;
        held_q  <= held_d;
      end
      out_vld_q <= out_vld_d;
      beat_q    <= beat_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    out_peer_q  <= out_peer_d;
    out_byte_q  <= out_byte_d;
    reply_cmd_q <= reply_cmd_d;
  end

  // a byte is only taken while the output register is free or finishing
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && out_vld_q) |-> out_done)
    else $error("input taken while a result was still pending");

  // beat counter stays within the three reply positions
  a_beat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat_q != 2'd3)
    else $error("reply beat counter out of range");

  // a data beat is always a single first beat
  a_data_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_peer_q) |-> (beat_q == BeatFirst))
    else $error("data result on a later beat position");

  // a reply continues with its command beat after its first beat is transferred
  a_reply_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_peer_q && m_axis_tready_i && (beat_q == BeatFirst))
      |=> (out_vld_q && out_peer_q && (beat_q == BeatCmd)))
    else $error("reply sequence broken");

endmodule
